[rtl/core/spwm_pkg.sv]
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared types and register map constants for the six-channel PWM unit.
// ----------------------------------------------------------------------------
package spwm_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    localparam int OFS_BITS  = 7;
    localparam int SUB_BITS  = 4;
    localparam int CH_BITS   = OFS_BITS - SUB_BITS;
    localparam int CTRL_BITS = 4;
    localparam int DIV_BITS  = 8;
    localparam int DATA_BITS = 16;

    localparam logic [OFS_BITS-1:0] REG_ENABLE = 7'h60;
    localparam logic [OFS_BITS-1:0] REG_CLKDIV = 7'h61;
    localparam logic [OFS_BITS-1:0] REG_STATUS = 7'h62;
    localparam logic [OFS_BITS-1:0] REG_IMASK  = 7'h63;

    localparam logic [SUB_BITS-1:0] OFS_PERIOD = 4'h0;
    localparam logic [SUB_BITS-1:0] OFS_DUTY   = 4'h2;
    localparam logic [SUB_BITS-1:0] OFS_CTRL   = 4'h4;

    // control word bit positions
    localparam int CTL_EN  = 0;
    localparam int CTL_POL = 1;
    localparam int CTL_IE  = 2;

    typedef struct packed {
        logic fire;
        logic gate;
        logic wr_period;
        logic wr_duty;
        logic wr_ctrl;
    } t_chan_cmd;

    typedef struct packed {
        logic wrap;
        logic level;
    } t_chan_stat;

endpackage

[rtl/core/spwm_channel.sv]
// ----------------------------------------------------------------------------
// spwm_channel
// One PWM channel: period, duty, control and counter with its compare.
// ----------------------------------------------------------------------------
module spwm_channel #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spwm_pkg::t_chan_cmd             i_cmd,
    input  logic [COUNT_BITS-1:0]           i_wdata,
    output spwm_pkg::t_chan_stat            o_stat,
    output logic [COUNT_BITS-1:0]           o_period,
    output logic [COUNT_BITS-1:0]           o_duty,
    output logic [spwm_pkg::CTRL_BITS-1:0]  o_ctrl
);
    import spwm_pkg::*;

    logic [COUNT_BITS-1:0] r_period, n_period;
    logic [COUNT_BITS-1:0] r_duty,   n_duty;
    logic [COUNT_BITS-1:0] r_count,  n_count;
    logic [CTRL_BITS-1:0]  r_ctrl,   n_ctrl;
    logic                  running;
    logic                  wrap;

    assign running = i_cmd.gate & r_ctrl[CTL_EN];

    always_comb begin
        n_period = i_cmd.wr_period ? i_wdata : r_period;
        n_ctrl   = i_cmd.wr_ctrl ? i_wdata[CTRL_BITS-1:0] : r_ctrl;
        n_duty   = r_duty;
        if (i_cmd.wr_duty) begin
            n_duty = (i_wdata > r_period) ? r_period : i_wdata;
        end
        n_count = r_count;
        wrap    = 1'b0;
        if (i_cmd.fire && running) begin
            if (r_count >= r_period) begin
                n_count = '0;
                wrap    = r_ctrl[CTL_IE];
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_duty   <= '0;
            r_count  <= '0;
            r_ctrl   <= '0;
        end else begin
            r_period <= n_period;
            r_duty   <= n_duty;
            r_count  <= n_count;
            r_ctrl   <= n_ctrl;
        end
    end

    assign o_stat.wrap  = wrap;
    assign o_stat.level = i_cmd.gate & n_ctrl[CTL_EN] & ((n_count < n_duty) ^ n_ctrl[CTL_POL]);
    assign o_period     = r_period;
    assign o_duty       = r_duty;
    assign o_ctrl       = r_ctrl;

endmodule

[rtl/core/six_channel_pwm_peripheral_unit.sv]
// ----------------------------------------------------------------------------
// six_channel_pwm_peripheral_unit
// Multi-channel PWM timer with a byte/halfword register file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one item: a tick, a register
//   write or a register read (i_opcode, i_reg_offset, i_write_data).
//   Output channel (o_valid/i_ready) returns exactly one item per input item:
//   read data (zero unless a read), the PWM line levels and the interrupt
//   line, all as they stand after that item.
//   Accepted items are registered. Throughput: 1 item per cycle while
//   o_ready is high, set by the state update of prescaler and channels.
//   A two-entry output buffer (output register plus skid register) keeps
//   o_ready high for one more item while the receiver stalls; o_ready drops
//   only while both entries are full.
//   Reset (i_rst_n low, synchronous) clears the register file, counters, the
//   prescaler, interrupt status and mask, and empties the output buffer.
//   Register map: channel n at 0x10*n (+0 period, +2 duty, +4 control),
//   0x60 enable mask, 0x61 divider, 0x62 status (write 1 to clear),
//   0x63 interrupt mask.
// ----------------------------------------------------------------------------
module six_channel_pwm_peripheral_unit #(
    parameter int NUM_CHANNELS = 6,
    parameter int COUNT_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [spwm_pkg::OFS_BITS-1:0]    i_reg_offset,
    input  logic [spwm_pkg::DATA_BITS-1:0]   i_write_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [spwm_pkg::DATA_BITS-1:0]   o_read_data,
    output logic [NUM_CHANNELS-1:0]          o_pwm_lines,
    output logic                             o_irq_line
);
    import spwm_pkg::*;

    localparam int NUM_SLOTS = 2 ** CH_BITS;

    logic                    accept;
    logic [CH_BITS-1:0]      ch;
    logic [SUB_BITS-1:0]     sub;
    logic                    glob_hit;
    logic                    is_tick;
    logic                    is_write;
    logic                    is_read;
    logic                    fire;

    logic [NUM_CHANNELS-1:0] r_mask,   n_mask;
    logic [DIV_BITS-1:0]     r_div,    n_div;
    logic [DIV_BITS-1:0]     r_presc,  n_presc;
    logic [NUM_CHANNELS-1:0] r_status, n_status;
    logic [NUM_CHANNELS-1:0] r_imask,  n_imask;

    logic [NUM_CHANNELS-1:0] wrap_vec;
    logic [NUM_CHANNELS-1:0] level_vec;
    logic [DATA_BITS-1:0]    rd_period [NUM_SLOTS];
    logic [DATA_BITS-1:0]    rd_duty   [NUM_SLOTS];
    logic [DATA_BITS-1:0]    rd_ctrl   [NUM_SLOTS];
    logic [DATA_BITS-1:0]    read_val;

    logic                    r_out_valid, n_out_valid;
    logic                    r_skid_valid, n_skid_valid;
    logic                    load_out_new;
    logic                    load_out_skid;
    logic                    load_skid;
    logic [DATA_BITS-1:0]    r_out_rdata,  r_skid_rdata;
    logic [NUM_CHANNELS-1:0] r_out_pwm,    r_skid_pwm;
    logic                    r_out_irq,    r_skid_irq;
    logic                    new_irq;

    assign o_ready  = !r_skid_valid;
    assign accept   = i_valid & o_ready;
    assign ch       = i_reg_offset[OFS_BITS-1:SUB_BITS];
    assign sub      = i_reg_offset[SUB_BITS-1:0];
    assign glob_hit = (i_reg_offset == REG_ENABLE) || (i_reg_offset == REG_CLKDIV) ||
                      (i_reg_offset == REG_STATUS) || (i_reg_offset == REG_IMASK);
    assign is_tick  = accept && (i_opcode == OP_TICK);
    assign is_write = accept && (i_opcode == OP_WRITE);
    assign is_read  = accept && (i_opcode == OP_READ);

    // prescaler
    assign fire = is_tick && (r_presc >= r_div);

    always_comb begin
        n_presc = r_presc;
        if (is_tick) begin
            n_presc = fire ? '0 : r_presc + 1'b1;
        end
    end

    // global register writes
    always_comb begin
        n_mask  = r_mask;
        n_div   = r_div;
        n_imask = r_imask;
        if (is_write) begin
            unique case (i_reg_offset)
                REG_ENABLE: n_mask  = i_write_data[NUM_CHANNELS-1:0];
                REG_CLKDIV: n_div   = i_write_data[DIV_BITS-1:0];
                REG_IMASK:  n_imask = i_write_data[NUM_CHANNELS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_status = r_status | wrap_vec;
        if (is_write && (i_reg_offset == REG_STATUS)) begin
            n_status = r_status & ~i_write_data[NUM_CHANNELS-1:0];
        end
    end

    // channels
    for (genvar n = 0; n < NUM_SLOTS; n++) begin : g_chan
        if (n < NUM_CHANNELS) begin : g_on
            t_chan_cmd             cmd;
            t_chan_stat            stat;
            logic [COUNT_BITS-1:0] period;
            logic [COUNT_BITS-1:0] duty;
            logic [CTRL_BITS-1:0]  ctrl;
            logic                  sel;

            assign sel           = is_write && !glob_hit && (ch == CH_BITS'(n));
            assign cmd.fire      = fire;
            assign cmd.gate      = n_mask[n];
            assign cmd.wr_period = sel && (sub == OFS_PERIOD);
            assign cmd.wr_duty   = sel && (sub == OFS_DUTY);
            assign cmd.wr_ctrl   = sel && (sub == OFS_CTRL);

            spwm_channel #(
                .COUNT_BITS(COUNT_BITS)
            ) u_chan (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (cmd),
                .i_wdata  (COUNT_BITS'(i_write_data)),
                .o_stat   (stat),
                .o_period (period),
                .o_duty   (duty),
                .o_ctrl   (ctrl)
            );

            assign wrap_vec[n]  = stat.wrap;
            assign level_vec[n] = stat.level;
            assign rd_period[n] = DATA_BITS'(period);
            assign rd_duty[n]   = DATA_BITS'(duty);
            assign rd_ctrl[n]   = DATA_BITS'(ctrl);
        end else begin : g_off
            assign rd_period[n] = '0;
            assign rd_duty[n]   = '0;
            assign rd_ctrl[n]   = '0;
        end
    end

    // register read
    always_comb begin
        read_val = '0;
        if (is_read) begin
            if (glob_hit) begin
                unique case (i_reg_offset)
                    REG_ENABLE: read_val = DATA_BITS'(r_mask);
                    REG_CLKDIV: read_val = DATA_BITS'(r_div);
                    REG_STATUS: read_val = DATA_BITS'(r_status);
                    REG_IMASK:  read_val = DATA_BITS'(r_imask);
                    default:    read_val = '0;
                endcase
            end else begin
                unique case (sub)
                    OFS_PERIOD: read_val = rd_period[ch];
                    OFS_DUTY:   read_val = rd_duty[ch];
                    OFS_CTRL:   read_val = rd_ctrl[ch];
                    default:    read_val = '0;
                endcase
            end
        end
    end

    assign new_irq = |(n_status & ~n_imask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_div    <= '0;
            r_presc  <= '0;
            r_status <= '0;
            r_imask  <= '0;
        end else begin
            r_mask   <= n_mask;
            r_div    <= n_div;
            r_presc  <= n_presc;
            r_status <= n_status;
            r_imask  <= n_imask;
        end
    end

    // output register and skid register
    always_comb begin
        load_out_skid = r_skid_valid && i_ready;
        load_out_new  = accept && (!r_out_valid || i_ready);
        load_skid     = accept && r_out_valid && !i_ready;
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        if (load_out_skid) begin
            n_skid_valid = 1'b0;
        end else if (load_out_new) begin
            n_out_valid = 1'b1;
        end else if (load_skid) begin
            n_skid_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_skid) begin
            r_out_rdata <= r_skid_rdata;
            r_out_pwm   <= r_skid_pwm;
            r_out_irq   <= r_skid_irq;
        end else if (load_out_new) begin
            r_out_rdata <= read_val;
            r_out_pwm   <= level_vec;
            r_out_irq   <= new_irq;
        end
        if (load_skid) begin
            r_skid_rdata <= read_val;
            r_skid_pwm   <= level_vec;
            r_skid_irq   <= new_irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_rdata;
    assign o_pwm_lines = r_out_pwm;
    assign o_irq_line  = r_out_irq;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_presc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && is_tick && (r_presc < r_div)) |=> (r_presc == $past(r_presc) + 1'b1))
        else $error("prescaler failed to advance");

    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && is_write && (i_reg_offset == REG_STATUS))
            |=> ((r_status & $past(i_write_data[NUM_CHANNELS-1:0])) == '0))
        else $error("status bit not cleared by write of one");

    a_no_fire_off_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status & ~$past(r_status)) != '0 |-> $past(fire))
        else $error("status bit set without a prescaler fire");

endmodule
